// ----- rtl/dvr_pkg.sv -----
// shared types and constants for the distance-vector route engine
`default_nettype none
package dvr_pkg;
    localparam int NODES_DEF = 32;
    localparam logic [9:0] NO_LINK = 10'd999;
    localparam logic [5:0] NODE_COUNT_RST = 6'd32;
    localparam logic [4:0] TRACE_LAST = 5'd31;

    localparam logic [2:0] OP_SET = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_RECOMPUTE = 3'd2;
    localparam logic [2:0] OP_READ = 3'd3;
    localparam logic [2:0] OP_TRACE = 3'd4;

    localparam logic [1:0] KIND_ACK = 2'd0;
    localparam logic [1:0] KIND_ENTRY = 2'd1;
    localparam logic [1:0] KIND_HOP = 2'd2;

    typedef struct packed {
        logic [2:0] opcode;
        logic [4:0] node_a;
        logic [4:0] node_b;
        logic [9:0] link_cost;
    } t_in_word;

    typedef struct packed {
        logic [1:0] kind;
        logic       reachable;
        logic [9:0] route_cost;
        logic [4:0] hop_node;
        logic       last;
    } t_out_word;

    typedef struct packed {
        logic       take;
        logic [9:0] cost;
    } t_relax_res;
endpackage
`default_nettype wire

// ----- rtl/dvr_link_mem.sv -----
// link cost table memory, one read and one write port
`default_nettype none
module dvr_link_mem #(
    parameter int NI = 5
) (
    input  wire logic            i_clk,
    input  wire logic [2*NI-1:0] i_rd_addr,
    output logic [9:0]           o_rd_cost,
    input  wire logic            i_we,
    input  wire logic [2*NI-1:0] i_wr_addr,
    input  wire logic [9:0]      i_wr_cost
);
    localparam int DEPTH = 2 ** (2 * NI);
    logic [9:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_cost;
        end
        o_rd_cost <= r_mem[i_rd_addr];
    end
endmodule
`default_nettype wire

// ----- rtl/dvr_route_mem.sv -----
// routing table memory: cost and next hop, two read ports and one write port
`default_nettype none
module dvr_route_mem #(
    parameter int NI = 5
) (
    input  wire logic            i_clk,
    input  wire logic [2*NI-1:0] i_a_addr,
    output logic [9:0]           o_a_cost,
    output logic [NI-1:0]        o_a_hop,
    output logic                 o_a_hv,
    input  wire logic [2*NI-1:0] i_b_addr,
    output logic [9:0]           o_b_cost,
    output logic [NI-1:0]        o_b_hop,
    output logic                 o_b_hv,
    input  wire logic            i_we,
    input  wire logic [2*NI-1:0] i_wr_addr,
    input  wire logic [9:0]      i_wr_cost,
    input  wire logic [NI-1:0]   i_wr_hop,
    input  wire logic            i_wr_hv
);
    localparam int DEPTH = 2 ** (2 * NI);
    localparam int EW = 11 + NI;
    logic [EW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= {i_wr_hv, i_wr_hop, i_wr_cost};
        end
        {o_a_hv, o_a_hop, o_a_cost} <= r_mem[i_a_addr];
        {o_b_hv, o_b_hop, o_b_cost} <= r_mem[i_b_addr];
    end
endmodule
`default_nettype wire

// ----- rtl/dvr_relax_unit.sv -----
// shared relaxation unit: widened sum and tie-aware compare
`default_nettype none
module dvr_relax_unit #(
    parameter int NI = 5
) (
    input  wire logic [9:0]    i_link_cost,
    input  wire logic [9:0]    i_cost_jk,
    input  wire logic [9:0]    i_cost_ik,
    input  wire logic          i_hv_ik,
    input  wire logic [NI-1:0] i_hop_ik,
    input  wire logic [NI-1:0] i_j,
    output dvr_pkg::t_relax_res o_res
);
    logic [10:0] w_sum;
    logic        w_better;
    logic        w_tie;

    always_comb begin
        w_sum = {1'b0, i_link_cost} + {1'b0, i_cost_jk};
        w_better = w_sum < {1'b0, i_cost_ik};
        // equal cost goes to the smaller next hop
        w_tie = (w_sum == {1'b0, i_cost_ik}) && (!i_hv_ik || (i_j < i_hop_ik));
        o_res.take = (w_sum < {1'b0, dvr_pkg::NO_LINK}) && (w_better || w_tie);
        o_res.cost = w_sum[9:0];
    end
endmodule
`default_nettype wire

// ----- rtl/distance_vector_route_engine.sv -----
// every result word is held until the output takes it, and a trace resumes only after that
// recompute: a table init pass copies every link table entry into the route table, then per round and pair
//   a link read, plus a route read and a compare-and-write per destination where a link exists
// one word in flight at a time; the single route table port pair sets the pace
// reset (synchronous, active low) starts a clearing pass over all 2^(2*clog2(NODES)) entries
//   of both tables, during which no input word is taken; node_count resets to 32
`default_nettype none
module distance_vector_route_engine #(
    parameter int NODES = dvr_pkg::NODES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire dvr_pkg::t_in_word  i_word,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output dvr_pkg::t_out_word      o_word,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [5:0]         i_cfg_data
);
    localparam int NI = $clog2(NODES);
    localparam int AW = 2 * NI;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_LNK0, S_LNK1, S_ACK, S_RD, S_RD_D, S_TR_A, S_TR_C,
        S_TR_RD, S_TR_D, S_INI_RD, S_INI_WR, S_REL_L, S_REL_LD, S_REL_RD
    } t_state;

    t_state r_state;
    logic          r_rel_wr;
    logic [NI-1:0] r_a, r_b, r_i, r_j, r_k, r_c, r_nlast, r_cur;
    logic [9:0]    r_lv, r_lc, r_cost;
    logic [AW-1:0] r_addr;
    logic [4:0]    r_tcnt;
    logic          r_more;
    logic [5:0]    r_node_count;

    logic [9:0]    w_link_rd;
    logic [9:0]    w_a_cost, w_b_cost;
    logic [NI-1:0] w_a_hop, w_b_hop;
    logic          w_a_hv, w_b_hv;
    dvr_pkg::t_relax_res w_res;

    logic          w_diag, w_ok, w_addr_end, w_trace_last;
    logic [6:0]    w_cnt7, w_neff7;
    logic [AW-1:0] w_lk_rd_addr, w_lk_wr_addr, w_rt_a_addr, w_rt_wr_addr;
    logic          w_lk_we, w_rt_we, w_rt_wr_hv;
    logic [9:0]    w_lk_wr_cost, w_rt_wr_cost;
    logic [NI-1:0] w_rt_wr_hop;

    assign o_cfg_ready = 1'b1;
    assign o_ready = (r_state == S_IDLE) && !o_valid;

    always_comb begin
        w_diag = r_addr[AW-1:NI] == r_addr[NI-1:0];
        w_addr_end = &r_addr;
        w_ok = ({2'b0, i_word.node_a} < 7'(NODES)) && ({2'b0, i_word.node_b} < 7'(NODES));
        w_cnt7 = {1'b0, r_node_count};
        if (w_cnt7 == 7'd0) begin
            w_neff7 = 7'd1;
        end else if (w_cnt7 > 7'(NODES)) begin
            w_neff7 = 7'(NODES);
        end else begin
            w_neff7 = w_cnt7;
        end
        w_trace_last = !w_a_hv || (w_a_hop == r_b) || (r_tcnt == dvr_pkg::TRACE_LAST);

        w_lk_rd_addr = (r_state == S_INI_RD) ? r_addr : {r_i, r_j};
        w_lk_we = (r_state == S_CLR) || (r_state == S_LNK0) || (r_state == S_LNK1);
        case (r_state)
            S_CLR: begin
                w_lk_wr_addr = r_addr;
                w_lk_wr_cost = w_diag ? 10'd0 : dvr_pkg::NO_LINK;
            end
            S_LNK0: begin
                w_lk_wr_addr = {r_a, r_b};
                w_lk_wr_cost = r_lv;
            end
            default: begin
                w_lk_wr_addr = {r_b, r_a};
                w_lk_wr_cost = r_lv;
            end
        endcase

        w_rt_a_addr = (r_state == S_REL_RD) ? {r_j, r_k} : {r_cur, r_b};
        case (r_state)
            S_CLR: begin
                w_rt_we = 1'b1;
                w_rt_wr_addr = r_addr;
                w_rt_wr_cost = w_diag ? 10'd0 : dvr_pkg::NO_LINK;
                w_rt_wr_hop = r_addr[AW-1:NI];
                w_rt_wr_hv = w_diag;
            end
            S_INI_WR: begin
                w_rt_we = 1'b1;
                w_rt_wr_addr = r_addr;
                w_rt_wr_cost = w_link_rd;
                w_rt_wr_hop = w_diag ? r_addr[AW-1:NI] : r_addr[NI-1:0];
                w_rt_wr_hv = w_diag || (w_link_rd < dvr_pkg::NO_LINK);
            end
            default: begin
                w_rt_we = r_rel_wr && w_res.take;
                w_rt_wr_addr = {r_i, r_k};
                w_rt_wr_cost = w_res.cost;
                w_rt_wr_hop = r_j;
                w_rt_wr_hv = 1'b1;
            end
        endcase
    end

    dvr_link_mem #(.NI(NI)) u_link (
        .i_clk     (i_clk),
        .i_rd_addr (w_lk_rd_addr),
        .o_rd_cost (w_link_rd),
        .i_we      (w_lk_we),
        .i_wr_addr (w_lk_wr_addr),
        .i_wr_cost (w_lk_wr_cost)
    );

    dvr_route_mem #(.NI(NI)) u_route (
        .i_clk     (i_clk),
        .i_a_addr  (w_rt_a_addr),
        .o_a_cost  (w_a_cost),
        .o_a_hop   (w_a_hop),
        .o_a_hv    (w_a_hv),
        .i_b_addr  ({r_i, r_k}),
        .o_b_cost  (w_b_cost),
        .o_b_hop   (w_b_hop),
        .o_b_hv    (w_b_hv),
        .i_we      (w_rt_we),
        .i_wr_addr (w_rt_wr_addr),
        .i_wr_cost (w_rt_wr_cost),
        .i_wr_hop  (w_rt_wr_hop),
        .i_wr_hv   (w_rt_wr_hv)
    );

    dvr_relax_unit #(.NI(NI)) u_relax (
        .i_link_cost (r_lc),
        .i_cost_jk   (w_a_cost),
        .i_cost_ik   (w_b_cost),
        .i_hv_ik     (w_b_hv),
        .i_hop_ik    (w_b_hop),
        .i_j         (r_j),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_addr <= '0;
            o_valid <= 1'b0;
            r_more <= 1'b0;
            r_rel_wr <= 1'b0;
            r_node_count <= dvr_pkg::NODE_COUNT_RST;
        end else begin
            if (i_cfg_valid) begin
                r_node_count <= i_cfg_data;
            end
            // reads issued while r_rel_wr is low, compare and write while it is high
            r_rel_wr <= (r_state == S_REL_RD) && !r_rel_wr;
            case (r_state)
                S_CLR: begin
                    r_addr <= r_addr + 1'b1;
                    if (w_addr_end) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_valid) begin
                        if (i_ready) begin
                            o_valid <= 1'b0;
                            if (r_more) begin
                                r_state <= S_TR_RD;
                            end
                        end
                    end else if (i_valid) begin
                        r_a <= NI'(i_word.node_a);
                        r_b <= NI'(i_word.node_b);
                        r_cur <= NI'(i_word.node_a);
                        r_more <= 1'b0;
                        r_lv <= (i_word.opcode == dvr_pkg::OP_SET &&
                                 i_word.link_cost < dvr_pkg::NO_LINK) ?
                                i_word.link_cost : dvr_pkg::NO_LINK;
                        case (i_word.opcode)
                            dvr_pkg::OP_SET, dvr_pkg::OP_REMOVE: begin
                                r_state <= (w_ok && i_word.node_a != i_word.node_b) ?
                                           S_LNK0 : S_ACK;
                            end
                            dvr_pkg::OP_RECOMPUTE: begin
                                r_addr <= '0;
                                r_nlast <= NI'(w_neff7 - 7'd1);
                                r_state <= S_INI_RD;
                            end
                            dvr_pkg::OP_READ: begin
                                if (w_ok) begin
                                    r_state <= S_RD;
                                end else begin
                                    o_word <= {dvr_pkg::KIND_ENTRY, 1'b0, dvr_pkg::NO_LINK,
                                               5'd0, 1'b1};
                                    o_valid <= 1'b1;
                                end
                            end
                            dvr_pkg::OP_TRACE: begin
                                if (w_ok) begin
                                    r_state <= S_TR_A;
                                end else begin
                                    o_word <= {dvr_pkg::KIND_HOP, 1'b0, dvr_pkg::NO_LINK,
                                               i_word.node_a, 1'b1};
                                    o_valid <= 1'b1;
                                end
                            end
                            default: begin
                                r_state <= S_ACK;
                            end
                        endcase
                    end
                end
                S_LNK0: r_state <= S_LNK1;
                S_LNK1: r_state <= S_ACK;
                S_ACK: begin
                    o_word <= {dvr_pkg::KIND_ACK, 1'b0, 10'd0, 5'd0, 1'b1};
                    o_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_RD: r_state <= S_RD_D;
                S_RD_D: begin
                    o_word <= {dvr_pkg::KIND_ENTRY, w_a_cost < dvr_pkg::NO_LINK, w_a_cost,
                               w_a_hv ? 5'(w_a_hop) : 5'd0, 1'b1};
                    o_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_TR_A: r_state <= S_TR_C;
                S_TR_C: begin
                    r_cost <= w_a_cost;
                    r_tcnt <= '0;
                    if (w_a_cost >= dvr_pkg::NO_LINK) begin
                        o_word <= {dvr_pkg::KIND_HOP, 1'b0, dvr_pkg::NO_LINK, 5'(r_a), 1'b1};
                        o_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_TR_RD;
                    end
                end
                S_TR_RD: r_state <= S_TR_D;
                S_TR_D: begin
                    // emit current hop, then step to its next hop
                    o_word <= {dvr_pkg::KIND_HOP, 1'b1, r_cost, 5'(r_cur), w_trace_last};
                    o_valid <= 1'b1;
                    r_more <= !w_trace_last;
                    r_cur <= w_a_hop;
                    r_tcnt <= r_tcnt + 5'd1;
                    r_state <= S_IDLE;
                end
                S_INI_RD: r_state <= S_INI_WR;
                S_INI_WR: begin
                    r_addr <= r_addr + 1'b1;
                    if (w_addr_end) begin
                        r_i <= '0;
                        r_j <= '0;
                        r_c <= '0;
                        r_state <= S_REL_L;
                    end else begin
                        r_state <= S_INI_RD;
                    end
                end
                S_REL_L: r_state <= S_REL_LD;
                S_REL_LD, S_REL_RD: begin
                    if (r_state == S_REL_LD) begin
                        r_lc <= w_link_rd;
                        r_k <= '0;
                    end
                    if (r_state == S_REL_LD && r_i != r_j && w_link_rd < dvr_pkg::NO_LINK) begin
                        r_state <= S_REL_RD;
                    end else if (r_state == S_REL_RD && !r_rel_wr) begin
                        // wait for the read data of this destination
                    end else if (r_state == S_REL_RD && r_k != r_nlast) begin
                        r_k <= r_k + 1'b1;
                    end else if (r_j != r_nlast) begin
                        r_j <= r_j + 1'b1;
                        r_state <= S_REL_L;
                    end else if (r_i != r_nlast) begin
                        r_j <= '0;
                        r_i <= r_i + 1'b1;
                        r_state <= S_REL_L;
                    end else if (r_c != r_nlast) begin
                        r_j <= '0;
                        r_i <= '0;
                        r_c <= r_c + 1'b1;
                        r_state <= S_REL_L;
                    end else begin
                        r_state <= S_ACK;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- rtl/dvr_checker.sv -----
// port-level checks for the route engine, bound to the top level
`default_nettype none
module dvr_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_ready,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire dvr_pkg::t_out_word i_out_word
);
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output word valid right after reset");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_word))
        else $error("stalled output word changed");
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input taken while a result is pending");
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_word.kind != 2'd3)
        else $error("bad result kind");
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_word.kind != dvr_pkg::KIND_HOP |-> i_out_word.last)
        else $error("non-trace result not marked last");
endmodule

bind distance_vector_route_engine dvr_checker u_dvr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (o_ready),
    .i_out_valid (o_valid),
    .i_out_ready (i_ready),
    .i_out_word  (o_word)
);
`default_nettype wire

// ----- sim/tb_top.sv -----
// testbench for the distance-vector route engine: directed table, random traffic, route predictor
`timescale 1ns / 1ps
module tb_top;
    localparam int N = 32;
    localparam logic [5:0] HOP_NONE = 6'h3F;
    localparam int WATCHDOG_LIMIT = 800000;
    localparam int N_DIRECTED = 25;
    localparam int N_PHASES = 8;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    dvr_pkg::t_in_word  i_word;
    logic      o_valid;
    logic      i_ready;
    dvr_pkg::t_out_word o_word;
    logic      i_cfg_valid;
    logic      o_cfg_ready;
    logic [5:0] i_cfg_data;

    distance_vector_route_engine #(.NODES(N)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_word(i_word),
        .o_valid(o_valid), .i_ready(i_ready), .o_word(o_word),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    // predictor state
    logic [9:0] link_cost_q [N][N];
    logic [9:0] route_cost_q [N][N];
    logic [5:0] next_hop_q [N][N];
    logic [5:0] node_count_q;

    dvr_pkg::t_out_word pending_results[$];
    int mismatches, words_in, words_out, recomputes, traces, cfg_writes;
    int idle_cycles;
    bit hold_req;
    int burst_left;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int eff_nodes();
        if (node_count_q == 0) return 1;
        if (node_count_q > N) return N;
        return node_count_q;
    endfunction

    function automatic int link_entries();
        int cnt;
        cnt = 0;
        for (int i = 0; i < N; i++)
            for (int j = 0; j < N; j++)
                if (i != j && link_cost_q[i][j] < dvr_pkg::NO_LINK) cnt++;
        return cnt;
    endfunction

    task automatic reset_tables();
        for (int i = 0; i < N; i++)
            for (int j = 0; j < N; j++) begin
                link_cost_q[i][j] = (i == j) ? 10'd0 : dvr_pkg::NO_LINK;
                route_cost_q[i][j] = (i == j) ? 10'd0 : dvr_pkg::NO_LINK;
                next_hop_q[i][j] = (i == j) ? 6'(i) : HOP_NONE;
            end
        node_count_q = dvr_pkg::NODE_COUNT_RST;
    endtask

    task automatic rebuild_routes();
        int n;
        logic [10:0] s;
        n = eff_nodes();
        for (int i = 0; i < N; i++)
            for (int j = 0; j < N; j++) begin
                route_cost_q[i][j] = link_cost_q[i][j];
                if (i == j) next_hop_q[i][j] = 6'(i);
                else if (link_cost_q[i][j] < dvr_pkg::NO_LINK) next_hop_q[i][j] = 6'(j);
                else next_hop_q[i][j] = HOP_NONE;
            end
        for (int c = 0; c < n; c++)
            for (int i = 0; i < n; i++)
                for (int j = 0; j < n; j++) begin
                    if (i == j || link_cost_q[i][j] >= dvr_pkg::NO_LINK) continue;
                    for (int k = 0; k < n; k++) begin
                        s = {1'b0, link_cost_q[i][j]} + {1'b0, route_cost_q[j][k]};
                        if (s >= dvr_pkg::NO_LINK) continue;
                        if (s < route_cost_q[i][k]) begin
                            route_cost_q[i][k] = s[9:0];
                            next_hop_q[i][k] = 6'(j);
                        end else if (s == route_cost_q[i][k] && j < next_hop_q[i][k]) begin
                            next_hop_q[i][k] = 6'(j);
                        end
                    end
                end
    endtask

    task automatic queue_result(input dvr_pkg::t_out_word r);
        pending_results = {pending_results, r};
    endtask

    // applies one word to the predictor and queues the words it should produce
    task automatic route_model_step(input dvr_pkg::t_in_word w);
        dvr_pkg::t_out_word r;
        logic [9:0] v;
        logic [5:0] nh;
        int cur, cnt;
        r = '0;
        r.last = 1'b1;
        case (w.opcode)
            dvr_pkg::OP_SET, dvr_pkg::OP_REMOVE: begin
                if (w.node_a != w.node_b) begin
                    v = (w.opcode == dvr_pkg::OP_SET && w.link_cost < dvr_pkg::NO_LINK) ?
                        w.link_cost : dvr_pkg::NO_LINK;
                    link_cost_q[w.node_a][w.node_b] = v;
                    link_cost_q[w.node_b][w.node_a] = v;
                end
                queue_result(r);
            end
            dvr_pkg::OP_RECOMPUTE: begin
                rebuild_routes();
                recomputes++;
                queue_result(r);
            end
            dvr_pkg::OP_READ: begin
                r.kind = dvr_pkg::KIND_ENTRY;
                r.route_cost = route_cost_q[w.node_a][w.node_b];
                r.reachable = r.route_cost < dvr_pkg::NO_LINK;
                nh = next_hop_q[w.node_a][w.node_b];
                r.hop_node = (nh == HOP_NONE) ? 5'd0 : nh[4:0];
                queue_result(r);
            end
            dvr_pkg::OP_TRACE: begin
                traces++;
                r.kind = dvr_pkg::KIND_HOP;
                if (route_cost_q[w.node_a][w.node_b] >= dvr_pkg::NO_LINK) begin
                    r.route_cost = dvr_pkg::NO_LINK;
                    r.hop_node = w.node_a;
                    queue_result(r);
                end else begin
                    r.reachable = 1'b1;
                    r.route_cost = route_cost_q[w.node_a][w.node_b];
                    cur = w.node_a;
                    cnt = 0;
                    forever begin
                        nh = next_hop_q[cur][w.node_b];
                        cnt++;
                        r.hop_node = 5'(cur);
                        r.last = (nh == w.node_b || nh == HOP_NONE || nh >= N || cnt >= 32);
                        queue_result(r);
                        if (r.last) break;
                        cur = nh;
                    end
                end
            end
            default: queue_result(r);
        endcase
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("mismatch on output word %0d: %s got %0d expected %0d",
                 words_out, what, got, want);
    endtask

    // output checker and watchdog
    always @(posedge i_clk) begin
        dvr_pkg::t_out_word e;
        if (i_rst_n && ((i_valid && o_ready) || (o_valid && i_ready)
                        || (i_cfg_valid && o_cfg_ready)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d words still expected", pending_results.size());
            $display("FAIL");
            $finish;
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word count", 1, 0);
            end else begin
                e = pending_results.pop_front();
                if (o_word.kind != e.kind) report_mismatch("kind", o_word.kind, e.kind);
                if (o_word.reachable != e.reachable)
                    report_mismatch("reachable", o_word.reachable, e.reachable);
                if (o_word.route_cost != e.route_cost)
                    report_mismatch("route_cost", o_word.route_cost, e.route_cost);
                if (o_word.hop_node != e.hop_node)
                    report_mismatch("hop_node", o_word.hop_node, e.hop_node);
                if (o_word.last != e.last) report_mismatch("last", o_word.last, e.last);
            end
            words_out <= words_out + 1;
        end
    end

    // receiver: own stall pattern, plus a long hold when asked
    initial begin
        int mode;
        int hold_cnt;
        mode = 0;
        hold_cnt = 0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_cnt = 400;
            end
            if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_ready <= 1'b0;
            end else begin
                case (mode)
                    0: i_ready <= 1'b1;
                    1: i_ready <= ($urandom_range(0, 3) != 0);
                    2: i_ready <= 1'($urandom_range(0, 1));
                    default: i_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    task automatic send_word(input dvr_pkg::t_in_word w, input bit typed,
                             input dvr_pkg::t_out_word want);
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_word <= w;
        do @(posedge i_clk); while (!o_ready);
        words_in++;
        route_model_step(w);
        if (typed) pending_results[pending_results.size() - 1] = want;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
                repeat ($urandom_range(0, 10)) @(negedge i_clk);
            end
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_node_count(input logic [5:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        node_count_q = val;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [4:0] pick_node(input int n);
        if ($urandom_range(0, 99) < 85) return 5'($urandom_range(0, n - 1));
        return 5'($urandom_range(0, 31));
    endfunction

    function automatic dvr_pkg::t_in_word random_word();
        dvr_pkg::t_in_word w;
        int n, sel, rc_pct;
        n = eff_nodes();
        rc_pct = (n > 16) ? 3 : 10;
        sel = $urandom_range(0, 99);
        w.node_a = pick_node(n);
        w.node_b = pick_node(n);
        w.link_cost = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1023))
                                                  : 10'($urandom_range(1, 30));
        if (sel < 35) w.opcode = dvr_pkg::OP_SET;
        else if (sel < 45) w.opcode = dvr_pkg::OP_REMOVE;
        else if (sel < 45 + rc_pct) w.opcode = dvr_pkg::OP_RECOMPUTE;
        else if (sel < 70) w.opcode = dvr_pkg::OP_READ;
        else if (sel < 95) w.opcode = dvr_pkg::OP_TRACE;
        else w.opcode = 3'($urandom_range(5, 7));
        // keep the link table sparse so recomputes over all nodes stay short
        if (w.opcode == dvr_pkg::OP_SET && link_entries() > 60) w.opcode = dvr_pkg::OP_REMOVE;
        return w;
    endfunction

    typedef struct {
        dvr_pkg::t_in_word  w;
        bit                 typed;
        dvr_pkg::t_out_word want;
    } t_stim_row;

    localparam dvr_pkg::t_out_word ACK = '{kind: dvr_pkg::KIND_ACK, reachable: 1'b0,
                                           route_cost: 10'd0, hop_node: 5'd0, last: 1'b1};

    t_stim_row directed[N_DIRECTED] = '{
        '{'{dvr_pkg::OP_READ, 5'd0, 5'd5, 10'd0}, 1'b1,
          '{dvr_pkg::KIND_ENTRY, 1'b0, dvr_pkg::NO_LINK, 5'd0, 1'b1}},
        '{'{dvr_pkg::OP_READ, 5'd31, 5'd31, 10'd0}, 1'b1,
          '{dvr_pkg::KIND_ENTRY, 1'b1, 10'd0, 5'd31, 1'b1}},
        '{'{dvr_pkg::OP_TRACE, 5'd2, 5'd9, 10'd0}, 1'b1,
          '{dvr_pkg::KIND_HOP, 1'b0, dvr_pkg::NO_LINK, 5'd2, 1'b1}},
        '{'{dvr_pkg::OP_TRACE, 5'd4, 5'd4, 10'd0}, 1'b1,
          '{dvr_pkg::KIND_HOP, 1'b1, 10'd0, 5'd4, 1'b1}},
        '{'{dvr_pkg::OP_SET, 5'd0, 5'd1, 10'd0}, 1'b1, ACK},
        '{'{dvr_pkg::OP_SET, 5'd1, 5'd2, 10'd998}, 1'b1, ACK},
        '{'{dvr_pkg::OP_SET, 5'd2, 5'd3, 10'd1023}, 1'b1, ACK},
        '{'{dvr_pkg::OP_SET, 5'd3, 5'd3, 10'd5}, 1'b1, ACK},
        '{'{dvr_pkg::OP_SET, 5'd2, 5'd3, 10'd7}, 1'b1, ACK},
        '{'{dvr_pkg::OP_SET, 5'd3, 5'd4, 10'd1}, 1'b1, ACK},
        '{'{dvr_pkg::OP_SET, 5'd0, 5'd4, 10'd500}, 1'b1, ACK},
        '{'{3'd5, 5'd31, 5'd31, 10'd1023}, 1'b1, ACK},
        '{'{3'd6, 5'd31, 5'd0, 10'd1023}, 1'b1, ACK},
        '{'{3'd7, 5'd0, 5'd31, 10'd512}, 1'b1, ACK},
        '{'{dvr_pkg::OP_READ, 5'd0, 5'd4, 10'd0}, 1'b0, ACK},
        '{'{dvr_pkg::OP_RECOMPUTE, 5'd0, 5'd0, 10'd0}, 1'b1, ACK},
        '{'{dvr_pkg::OP_READ, 5'd0, 5'd4, 10'd0}, 1'b0, ACK},
        '{'{dvr_pkg::OP_READ, 5'd4, 5'd0, 10'd0}, 1'b0, ACK},
        '{'{dvr_pkg::OP_TRACE, 5'd0, 5'd3, 10'd0}, 1'b0, ACK},
        '{'{dvr_pkg::OP_TRACE, 5'd0, 5'd2, 10'd0}, 1'b0, ACK},
        '{'{dvr_pkg::OP_REMOVE, 5'd1, 5'd2, 10'd0}, 1'b1, ACK},
        '{'{dvr_pkg::OP_REMOVE, 5'd7, 5'd7, 10'd0}, 1'b1, ACK},
        '{'{dvr_pkg::OP_RECOMPUTE, 5'd0, 5'd0, 10'd0}, 1'b1, ACK},
        '{'{dvr_pkg::OP_TRACE, 5'd0, 5'd2, 10'd0}, 1'b0, ACK},
        '{'{dvr_pkg::OP_READ, 5'd0, 5'd31, 10'd0}, 1'b0, ACK}
    };

    logic [5:0] phase_counts[N_PHASES] = '{6'd0, 6'd1, 6'd3, 6'd8, 6'd63, 6'd2, 6'd12, 6'd32};

    initial begin
        mismatches = 0; words_in = 0; words_out = 0; recomputes = 0; traces = 0;
        cfg_writes = 0; idle_cycles = 0; hold_req = 0; burst_left = 4;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_word = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        reset_tables();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_node_count(6'd5);
        foreach (directed[r]) send_word(directed[r].w, directed[r].typed, directed[r].want);
        drain();

        foreach (phase_counts[p]) begin
            write_node_count(phase_counts[p]);
            if (p == 1) hold_req = 1'b1;
            repeat (20) send_word(random_word(), 1'b0, ACK);
            // finish each phase with three random traces, mostly over the nodes in use
            repeat (3) begin
                dvr_pkg::t_in_word w;
                w = random_word();
                w.opcode = dvr_pkg::OP_TRACE;
                send_word(w, 1'b0, ACK);
            end
            drain();
        end

        $display("%0d words in, %0d words out, %0d recomputes, %0d traces, %0d config writes",
                 words_in, words_out, recomputes, traces, cfg_writes);
        $display("node counts from 0 to 63 exercised, with bursty input and output stalls");
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
